[rtl/core/rlc_am_receive_window_macros.svh]
// assertion macros of the receive window checker
`ifndef RLC_AM_RECEIVE_WINDOW_MACROS_SVH
`define RLC_AM_RECEIVE_WINDOW_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define RLCRW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLCRW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rlcrw_pkg.sv]
// shared codes and controller/datapath interface types of the receive window
package rlcrw_pkg;

    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    localparam logic [1:0] RES_REPORT   = 2'd0;
    localparam logic [1:0] RES_DELIVER  = 2'd1;
    localparam logic [1:0] RES_MOVE_ACK = 2'd2;
    localparam logic [1:0] RES_ERROR    = 2'd3;

    localparam logic [1:0] FRAG_MIDDLE = 2'd0;
    localparam logic [1:0] FRAG_FIRST  = 2'd1;
    localparam logic [1:0] FRAG_LAST   = 2'd2;
    localparam logic [1:0] FRAG_WHOLE  = 2'd3;

    // slot memory read address select
    localparam logic [1:0] ASEL_IDX   = 2'd0;
    localparam logic [1:0] ASEL_PTR   = 2'd1;
    localparam logic [1:0] ASEL_POSM1 = 2'd2;

    // walk pointer operations
    localparam logic [2:0] PTR_HOLD  = 3'd0;
    localparam logic [2:0] PTR_ZERO  = 3'd1;
    localparam logic [2:0] PTR_INC   = 3'd2;
    localparam logic [2:0] PTR_DEC   = 3'd3;
    localparam logic [2:0] PTR_IDXM1 = 3'd4;
    localparam logic [2:0] PTR_IDXP1 = 3'd5;
    localparam logic [2:0] PTR_POS   = 3'd6;

    typedef struct packed {
        logic       cap;
        logic [1:0] asel;
        logic [2:0] ptr_op;
        logic       first_idx;
        logic       first_ptr;
        logic       set_ne;
        logic       commit;
        logic       copy;
        logic       mv_pend;
        logic       mv_fin;
        logic       hide;
        logic       ld_out;
        logic [1:0] okind;
        logic       olast;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] frag;
        logic       stale;
        logic       beyond;
        logic       mv_fwd;
        logic       mv_fault;
        logic       idx_recv;
        logic       idx_zero;
        logic       idx_last;
        logic       pend_match;
        logic       oos;
        logic       rpt_ok;
        logic       rd_sdu_ne;
        logic [1:0] rd_kind;
        logic       e_recv;
        logic       ptr_zero;
        logic       ptr_last;
        logic       cum_stop;
        logic       pos_full;
        logic       out_free;
    } t_sts;

endpackage

[rtl/core/rlcrw_ctrl.sv]
// sequencing state machine of the receive window
module rlcrw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rlcrw_pkg::t_sts i_sts,
    output logic            o_in_ready,
    output rlcrw_pkg::t_cmd o_cmd
);
    import rlcrw_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DEC    = 5'd1;
    localparam logic [4:0] S_DUP    = 5'd2;
    localparam logic [4:0] S_SRCH   = 5'd3;
    localparam logic [4:0] S_BRD    = 5'd4;
    localparam logic [4:0] S_BEV    = 5'd5;
    localparam logic [4:0] S_FRD    = 5'd6;
    localparam logic [4:0] S_FEV    = 5'd7;
    localparam logic [4:0] S_COMMIT = 5'd8;
    localparam logic [4:0] S_RPT    = 5'd9;
    localparam logic [4:0] S_CUM    = 5'd10;
    localparam logic [4:0] S_ROUT   = 5'd11;
    localparam logic [4:0] S_DLV    = 5'd12;
    localparam logic [4:0] S_ERR    = 5'd13;
    localparam logic [4:0] S_MPEND  = 5'd14;
    localparam logic [4:0] S_CRD    = 5'd15;
    localparam logic [4:0] S_CWR    = 5'd16;
    localparam logic [4:0] S_MFIN   = 5'd17;
    localparam logic [4:0] S_MACK   = 5'd18;

    logic [4:0] r_state, n_state;
    logic       r_phase, n_phase;   // second report of a data PDU
    logic       r_dlv, n_dlv;       // an SDU is to be announced
    logic       r_oos, n_oos;
    logic       r_hide, n_hide;     // report must not see the new slot yet

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_dlv   <= 1'b0;
            r_oos   <= 1'b0;
            r_hide  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_dlv   <= n_dlv;
            r_oos   <= n_oos;
            r_hide  <= n_hide;
        end
    end

    always_comb begin
        logic back_ok;
        back_ok = 1'b0;
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        n_dlv   = r_dlv;
        n_oos   = r_oos;
        n_hide  = r_hide;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_phase = 1'b0;
                    n_dlv   = 1'b0;
                    n_oos   = 1'b0;
                    n_hide  = 1'b0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.asel = (i_sts.op == OP_MOVE) ? ASEL_POSM1 : ASEL_IDX;
                unique case (i_sts.op)
                    OP_DATA: begin
                        priority if (i_sts.stale) n_state = S_IDLE;
                        else if (i_sts.beyond)    n_state = S_ERR;
                        else                      n_state = S_DUP;
                    end
                    OP_MOVE: begin
                        o_cmd.ptr_op = PTR_POS;
                        priority if (i_sts.mv_fault) n_state = S_ERR;
                        else if (!i_sts.mv_fwd)      n_state = S_MACK;
                        else                         n_state = S_MPEND;
                    end
                    OP_REPORT: n_state = S_RPT;
                    default:   n_state = S_ERR;
                endcase
            end
            S_DUP: begin
                n_oos = i_sts.oos;
                if (i_sts.idx_recv) begin
                    if (i_sts.rd_sdu_ne) begin
                        n_state = S_ERR;
                    end else begin
                        o_cmd.set_ne = 1'b1;
                        n_state = i_sts.oos ? S_RPT : S_IDLE;
                    end
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                priority if (i_sts.frag == FRAG_WHOLE) begin
                    o_cmd.first_idx = 1'b1;
                    n_dlv   = 1'b1;
                    n_state = S_COMMIT;
                end else if (i_sts.frag == FRAG_FIRST) begin
                    back_ok = 1'b1;
                end else if (i_sts.idx_zero) begin
                    if (!i_sts.pend_match) n_state = S_ERR;
                    else                   back_ok = 1'b1;
                end else begin
                    o_cmd.ptr_op = PTR_IDXM1;
                    n_state = S_BRD;
                end
                if (back_ok) begin
                    o_cmd.first_idx = 1'b1;
                    priority if (i_sts.frag == FRAG_LAST) begin
                        n_dlv   = 1'b1;
                        n_state = S_COMMIT;
                    end else if (i_sts.idx_last) begin
                        n_state = S_COMMIT;
                    end else begin
                        o_cmd.ptr_op = PTR_IDXP1;
                        n_state = S_FRD;
                    end
                end
            end
            S_BRD: begin
                o_cmd.asel = ASEL_PTR;
                n_state = S_BEV;
            end
            S_BEV: begin
                priority if (!i_sts.e_recv) begin
                    n_state = S_COMMIT;
                end else if (i_sts.rd_sdu_ne) begin
                    n_state = S_ERR;
                end else if (i_sts.rd_kind == FRAG_FIRST) begin
                    o_cmd.first_ptr = 1'b1;
                    priority if (i_sts.frag == FRAG_LAST) begin
                        n_dlv   = 1'b1;
                        n_state = S_COMMIT;
                    end else if (i_sts.idx_last) begin
                        n_state = S_COMMIT;
                    end else begin
                        o_cmd.ptr_op = PTR_IDXP1;
                        n_state = S_FRD;
                    end
                end else if (i_sts.rd_kind != FRAG_MIDDLE) begin
                    n_state = S_ERR;
                end else if (i_sts.ptr_zero) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.ptr_op = PTR_DEC;
                    n_state = S_BRD;
                end
            end
            S_FRD: begin
                o_cmd.asel = ASEL_PTR;
                n_state = S_FEV;
            end
            S_FEV: begin
                priority if (!i_sts.e_recv) begin
                    n_state = S_COMMIT;
                end else if (i_sts.rd_sdu_ne) begin
                    n_state = S_ERR;
                end else if (i_sts.rd_kind == FRAG_LAST) begin
                    n_dlv   = 1'b1;
                    n_state = S_COMMIT;
                end else if (i_sts.rd_kind != FRAG_MIDDLE) begin
                    n_state = S_ERR;
                end else if (i_sts.ptr_last) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state = S_FRD;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_hide = 1'b1;
                priority if (r_oos) n_state = S_RPT;
                else if (r_dlv)     n_state = S_DLV;
                else                n_state = S_IDLE;
            end
            S_RPT: begin
                if (i_sts.rpt_ok) begin
                    o_cmd.ptr_op = PTR_ZERO;
                    n_state = S_CUM;
                end else begin
                    n_state = (!r_phase && r_dlv) ? S_DLV : S_IDLE;
                end
            end
            S_CUM: begin
                o_cmd.hide = r_hide;
                if (i_sts.cum_stop) n_state = S_ROUT;
                else                o_cmd.ptr_op = PTR_INC;
            end
            S_ROUT: begin
                o_cmd.hide = r_hide;
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    o_cmd.okind  = RES_REPORT;
                    o_cmd.olast  = r_phase || !r_dlv;
                    n_state = (!r_phase && r_dlv) ? S_DLV : S_IDLE;
                end
            end
            S_DLV: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    o_cmd.okind  = RES_DELIVER;
                    o_cmd.olast  = !i_sts.rpt_ok;
                    n_phase = 1'b1;
                    n_hide  = 1'b0;
                    n_state = S_RPT;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    o_cmd.okind  = RES_ERROR;
                    o_cmd.olast  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MPEND: begin
                o_cmd.mv_pend = 1'b1;
                n_state = i_sts.pos_full ? S_MFIN : S_CRD;
            end
            S_CRD: begin
                o_cmd.asel = ASEL_PTR;
                n_state = S_CWR;
            end
            S_CWR: begin
                o_cmd.copy   = 1'b1;
                o_cmd.ptr_op = PTR_INC;
                n_state = i_sts.ptr_last ? S_MFIN : S_CRD;
            end
            S_MFIN: begin
                o_cmd.mv_fin = 1'b1;
                n_state = S_MACK;
            end
            S_MACK: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    o_cmd.okind  = RES_MOVE_ACK;
                    o_cmd.olast  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/core/rlcrw_dp.sv]
// window state, slot memory, walk pointer and result register of the receive window
module rlcrw_dp #(
    parameter int WINDOW_SIZE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rlcrw_pkg::t_cmd    i_cmd,
    output rlcrw_pkg::t_sts    o_sts,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_seq_num,
    input  logic [15:0]        i_sdu_id,
    input  logic [1:0]         i_frag_kind,
    input  logic [31:0]        i_now_time,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic signed [32:0] o_ack_last_sn,
    output logic [31:0]        o_bitmap_first_sn,
    output logic [31:0]        o_bitmap,
    output logic [5:0]         o_bitmap_len,
    output logic [15:0]        o_out_sdu_id,
    output logic               o_last
);
    import rlcrw_pkg::*;

    localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);
    localparam int BW = (WINDOW_SIZE > 32) ? WINDOW_SIZE : 32;

    // captured item
    logic [1:0]  r_op;
    logic [31:0] r_seq;
    logic [15:0] r_sdu;
    logic [1:0]  r_frag;
    logic [31:0] r_now;

    // window state
    logic [WINDOW_SIZE-1:0] r_recv;
    logic [17:0]            r_mem [WINDOW_SIZE];
    logic [17:0]            r_rdata;
    logic [31:0]            r_ws;
    logic [31:0]            r_ne;
    logic                   r_pend_none;
    logic [15:0]            r_pend_sdu;
    logic [31:0]            r_last_time;
    logic [31:0]            r_min;

    logic [CW-1:0] r_ptr;
    logic [IW-1:0] r_first;
    logic          r_cur_none;
    logic [15:0]   r_cur_sdu;

    logic               r_ovalid;
    logic [1:0]         r_okind;
    logic signed [32:0] r_oack;
    logic [31:0]        r_obfs;
    logic [31:0]        r_obm;
    logic [5:0]         r_olen;
    logic [15:0]        r_osdu;
    logic               r_olast;

    logic [31:0]            diff;
    logic [IW-1:0]          idx;
    logic [IW-1:0]          posm1;
    logic [CW-1:0]          pos;
    logic [IW-1:0]          ptr_idx;
    logic [IW-1:0]          raddr;
    logic [15:0]            rd_sdu;
    logic [1:0]             rd_kind;
    logic [15:0]            pend_eff;
    logic [WINDOW_SIZE-1:0] vec;
    logic [WINDOW_SIZE-1:0] shifted;
    logic [BW-1:0]          shx;
    logic [32:0]            sum33;
    logic [32:0]            sum_m1;
    logic signed [32:0]     rpt_ack;
    logic                   full;
    logic [CW-1:0]          rem;
    logic [5:0]             rpt_len;
    logic                   out_free;

    assign diff    = r_seq - r_ws;
    assign idx     = diff[IW-1:0];
    assign posm1   = IW'(diff - 32'd1);
    assign pos     = diff[CW-1:0];
    assign ptr_idx = r_ptr[IW-1:0];
    assign rd_sdu  = r_rdata[17:2];
    assign rd_kind = r_rdata[1:0];
    assign pend_eff = r_pend_none ? r_sdu : r_pend_sdu;
    assign out_free = !r_ovalid || i_out_ready;

    // the slot just taken stays out of the first report of its item
    assign vec = r_recv & ~(i_cmd.hide ? (WINDOW_SIZE'(1) << idx) : '0);

    // report fields from the cumulative count held in the walk pointer
    assign full    = (r_ptr == CW'(WINDOW_SIZE));
    assign shifted = vec >> r_ptr;
    assign shx     = BW'(shifted);
    assign sum33   = {1'b0, r_ws} + 33'(r_ptr);
    assign sum_m1  = sum33 - 33'd1;
    assign rem     = CW'(WINDOW_SIZE) - r_ptr;
    assign rpt_len = (32'(rem) > 32'd32) ? 6'd32 : 6'(rem);

    always_comb begin
        if (sum33 == '0)      rpt_ack = '1;
        else if (sum_m1[32])  rpt_ack = {1'b0, sum_m1[31:0]};
        else                  rpt_ack = sum_m1;
    end

    always_comb begin
        unique case (i_cmd.asel)
            ASEL_IDX:   raddr = idx;
            ASEL_PTR:   raddr = ptr_idx;
            ASEL_POSM1: raddr = posm1;
            default:    raddr = idx;
        endcase
    end

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.frag       = r_frag;
        o_sts.stale      = (r_seq < r_ws);
        o_sts.beyond     = (diff >= 32'(WINDOW_SIZE));
        o_sts.mv_fwd     = (r_seq > r_ws);
        o_sts.mv_fault   = (r_seq > r_ws) && (diff > 32'(WINDOW_SIZE));
        o_sts.idx_recv   = r_recv[idx];
        o_sts.idx_zero   = (idx == '0);
        o_sts.idx_last   = (idx == IW'(WINDOW_SIZE - 1));
        o_sts.pend_match = (pend_eff == r_sdu);
        o_sts.oos        = (r_seq != r_ne);
        o_sts.rpt_ok     = ((r_now - r_last_time) >= r_min);
        o_sts.rd_sdu_ne  = (rd_sdu != r_sdu);
        o_sts.rd_kind    = rd_kind;
        o_sts.e_recv     = r_recv[ptr_idx];
        o_sts.ptr_zero   = (r_ptr == '0);
        o_sts.ptr_last   = (r_ptr == CW'(WINDOW_SIZE - 1));
        o_sts.cum_stop   = full || !vec[ptr_idx];
        o_sts.pos_full   = (diff == 32'(WINDOW_SIZE));
        o_sts.out_free   = out_free;
    end

    // slot memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[raddr];
        if (i_cmd.commit) begin
            r_mem[idx] <= {r_sdu, r_frag};
        end else if (i_cmd.copy) begin
            r_mem[IW'(r_ptr - pos)] <= r_rdata;
        end
    end

    // payload, walk pointer, first-slot, pending-carry and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op   <= i_op;
            r_seq  <= i_seq_num;
            r_sdu  <= i_sdu_id;
            r_frag <= i_frag_kind;
            r_now  <= i_now_time;
        end
        unique case (i_cmd.ptr_op)
            PTR_ZERO:  r_ptr <= '0;
            PTR_INC:   r_ptr <= r_ptr + CW'(1);
            PTR_DEC:   r_ptr <= r_ptr - CW'(1);
            PTR_IDXM1: r_ptr <= CW'(idx) - CW'(1);
            PTR_IDXP1: r_ptr <= CW'(idx) + CW'(1);
            PTR_POS:   r_ptr <= pos;
            default:   r_ptr <= r_ptr;
        endcase
        if (i_cmd.first_idx) r_first <= idx;
        if (i_cmd.first_ptr) r_first <= ptr_idx;
        if (i_cmd.mv_pend) begin
            // pending SDU carried past the window edge by the last slot shifted out
            r_cur_none <= !r_recv[posm1] || (rd_kind >= FRAG_LAST);
            r_cur_sdu  <= rd_sdu;
        end
        if (i_cmd.ld_out) begin
            r_okind <= i_cmd.okind;
            r_olast <= i_cmd.olast;
            r_oack  <= '0;
            r_obfs  <= '0;
            r_obm   <= '0;
            r_olen  <= '0;
            r_osdu  <= '0;
            unique case (i_cmd.okind)
                RES_REPORT: begin
                    r_oack <= rpt_ack;
                    r_obfs <= full ? 32'd0 : sum33[31:0];
                    r_obm  <= shx[31:0];
                    r_olen <= rpt_len;
                end
                RES_DELIVER: begin
                    r_oack <= {1'b0, r_ws + 32'(r_first)};
                    r_osdu <= r_sdu;
                end
                RES_MOVE_ACK: begin
                    r_oack <= {1'b0, r_ws};
                    r_osdu <= r_sdu;
                end
                default: begin
                end
            endcase
        end
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv      <= '0;
            r_ws        <= '0;
            r_ne        <= '0;
            r_pend_none <= 1'b1;
            r_pend_sdu  <= '0;
            r_last_time <= '0;
            r_min       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_min <= i_cfg_data;
            if (i_cmd.set_ne) r_ne <= r_seq + 32'd1;
            if (i_cmd.commit) begin
                r_recv[idx] <= 1'b1;
                r_ne        <= r_seq + 32'd1;
                r_pend_none <= 1'b0;
                r_pend_sdu  <= pend_eff;
            end
            if (i_cmd.mv_fin) begin
                r_recv      <= r_recv >> pos;
                r_ws        <= r_seq;
                r_pend_none <= r_cur_none;
                r_pend_sdu  <= r_cur_sdu;
            end
            if (i_cmd.ld_out && (i_cmd.okind == RES_REPORT)) r_last_time <= r_now;
            if (i_cmd.ld_out)      r_ovalid <= 1'b1;
            else if (i_out_ready)  r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_kind            = r_okind;
    assign o_ack_last_sn     = r_oack;
    assign o_bitmap_first_sn = r_obfs;
    assign o_bitmap          = r_obm;
    assign o_bitmap_len      = r_olen;
    assign o_out_sdu_id      = r_osdu;
    assign o_last            = r_olast;

endmodule

[rtl/core/rlc_am_receive_window.sv]
// Receive window of an acknowledged-mode link receiver. One item is taken at a time
// on the input channel; results leave through an output register, so the next item
// is taken while the last result of the previous one still waits. After its transfer
// a placed data PDU is decoded, checked as a duplicate, searched backward and
// forward for its SDU one slot at a time as needed, and committed; a delivery and
// status report attempts follow where due, and a report that is sent counts its
// cumulative run slot by slot. A forward move copies the kept slots one at a time
// before the window edge moves. Each result may wait while the output register is
// not free. This stepping comes from the single read port of the slot memory,
// walked one slot at a time, and the slot-by-slot count of the cumulative
// acknowledgement. Configuration is always ready and is taken at once.
module rlc_am_receive_window #(
    parameter int WINDOW_SIZE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_seq_num,
    input  logic [15:0]        i_sdu_id,
    input  logic [1:0]         i_frag_kind,
    input  logic [31:0]        i_now_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic signed [32:0] o_ack_last_sn,
    output logic [31:0]        o_bitmap_first_sn,
    output logic [31:0]        o_bitmap,
    output logic [5:0]         o_bitmap_len,
    output logic [15:0]        o_out_sdu_id,
    output logic               o_last
);
    import rlcrw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rlcrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rlcrw_dp #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_seq_num         (i_seq_num),
        .i_sdu_id          (i_sdu_id),
        .i_frag_kind       (i_frag_kind),
        .i_now_time        (i_now_time),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_ack_last_sn     (o_ack_last_sn),
        .o_bitmap_first_sn (o_bitmap_first_sn),
        .o_bitmap          (o_bitmap),
        .o_bitmap_len      (o_bitmap_len),
        .o_out_sdu_id      (o_out_sdu_id),
        .o_last            (o_last)
    );

endmodule

[rtl/core/rlcrw_chk.sv]
// port-level checker of the receive window and its bind
`include "rlc_am_receive_window_macros.svh"

module rlcrw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_bitmap_first_sn,
    input logic [31:0] o_bitmap,
    input logic [5:0]  o_bitmap_len,
    input logic        o_last
);
    import rlcrw_pkg::*;

    `RLCRW_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_last), "result changed before transfer")
    `RLCRW_ASSERT_IMP(a_err_last, o_out_valid && (o_kind == RES_ERROR), o_last, "error result not final")
    `RLCRW_ASSERT_IMP(a_mack_last, o_out_valid && (o_kind == RES_MOVE_ACK), o_last, "move acknowledge not final")
    `RLCRW_ASSERT_IMP(a_nonrpt_zero, o_out_valid && (o_kind != RES_REPORT), (o_bitmap == '0) && (o_bitmap_len == '0) && (o_bitmap_first_sn == '0), "bitmap fields set outside a report")
    `RLCRW_ASSERT_IMP(a_len_max, o_out_valid, o_bitmap_len <= 6'd32, "bitmap length above 32")

endmodule

bind rlc_am_receive_window rlcrw_chk u_chk (.*);

[bench/rlc_am_receive_window_tb.sv]
// testbench for the receive window: random and directed traffic against a scoreboard
`timescale 1ns / 100ps

module rlc_am_receive_window_tb;
    import rlcrw_pkg::*;

    localparam int WIN = 32;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [32:0] ack;
        logic [31:0] bfs;
        logic [31:0] bm;
        logic [5:0]  blen;
        logic [15:0] sdu;
        logic        last;
    } t_win_result;

    class t_window_scoreboard;
        bit          recv [WIN];
        bit [15:0]   sdu_s [WIN];
        bit [1:0]    kind_s [WIN];
        bit [31:0]   ws;
        bit [31:0]   ne;
        int          pend;
        bit [31:0]   last_rpt;
        bit [31:0]   min_gap;
        bit          fault;
        t_win_result step_q[$];
        t_win_result pending_q[$];
        int          mismatches;

        function new();
            foreach (recv[i]) begin
                recv[i] = 0;
                sdu_s[i] = 0;
                kind_s[i] = 0;
            end
            ws = 0;
            ne = 0;
            pend = -1;
            last_rpt = 0;
            min_gap = 0;
            mismatches = 0;
        endfunction

        function void add(logic [1:0] k, logic [32:0] a, logic [31:0] f, logic [31:0] b,
                          logic [5:0] l, logic [15:0] s);
            t_win_result r;
            if (step_q.size() >= 3) return;
            r.kind = k; r.ack = a; r.bfs = f; r.bm = b; r.blen = l; r.sdu = s; r.last = 0;
            step_q.insert(step_q.size(), r);
        endfunction

        function void status_report(bit [31:0] now);
            int        cum;
            int        len;
            bit [31:0] bm;
            bit [31:0] bfs;
            longint    a;
            cum = 0; len = 0; bm = 0; bfs = 0;
            if (now - last_rpt < min_gap) return;
            while (cum < WIN && recv[cum]) cum++;
            a = longint'(ws) + cum - 1;
            if (a > longint'(32'hFFFF_FFFF)) a -= 64'h1_0000_0000;
            if (cum < WIN) begin
                bfs = ws + cum;
                for (int i = cum; i < WIN; i++) begin
                    if (len >= 32) break;
                    if (recv[i]) bm[len] = 1'b1;
                    len++;
                end
            end
            last_rpt = now;
            add(RES_REPORT, a[32:0], bfs, bm, len[5:0], 16'd0);
        endfunction

        function void deliver(int first, bit [31:0] now);
            bit [31:0] sn;
            sn = ws + first;
            add(RES_DELIVER, {1'b0, sn}, 0, 0, 0, sdu_s[first]);
            status_report(now);
        endfunction

        function void sdu_search(int idx, bit [31:0] now);
            bit [15:0] s;
            bit [1:0]  k;
            int        first;
            bit        back_ok;
            s = sdu_s[idx]; k = kind_s[idx]; first = idx; back_ok = 0;
            if (pend < 0) pend = s;
            if (k == FRAG_WHOLE) begin
                deliver(idx, now);
                return;
            end
            if (k == FRAG_FIRST) begin
                back_ok = 1;
            end else if (idx == 0) begin
                if (pend != int'(s)) begin
                    fault = 1;
                    return;
                end
                back_ok = 1;
            end else begin
                for (int i = idx - 1; i >= 0; i--) begin
                    if (!recv[i]) return;
                    if (sdu_s[i] != s) begin
                        fault = 1;
                        return;
                    end
                    if (kind_s[i] == FRAG_FIRST) begin
                        first = i;
                        back_ok = 1;
                        break;
                    end
                    if (kind_s[i] != FRAG_MIDDLE) begin
                        fault = 1;
                        return;
                    end
                end
            end
            if (!back_ok) return;
            if (k == FRAG_LAST) begin
                deliver(first, now);
                return;
            end
            for (int i = idx + 1; i < WIN; i++) begin
                if (!recv[i]) return;
                if (sdu_s[i] != s) begin
                    fault = 1;
                    return;
                end
                if (kind_s[i] == FRAG_LAST) begin
                    deliver(first, now);
                    return;
                end
                if (kind_s[i] != FRAG_MIDDLE) begin
                    fault = 1;
                    return;
                end
            end
        endfunction

        function void data_pdu(bit [31:0] seq, bit [15:0] s, bit [1:0] k, bit [31:0] now);
            bit [31:0] idx;
            if (seq < ws) return;
            idx = seq - ws;
            if (idx >= WIN) begin
                fault = 1;
                return;
            end
            if (seq == ne) begin
                ne = ne + 1;
            end else begin
                ne = seq + 1;
                status_report(now);
            end
            if (recv[idx]) begin
                if (sdu_s[idx] != s) fault = 1;
                return;
            end
            recv[idx] = 1;
            sdu_s[idx] = s;
            kind_s[idx] = k;
            sdu_search(int'(idx), now);
        endfunction

        function void move_window(bit [31:0] seq, bit [15:0] s);
            bit [31:0] pos;
            int        cur;
            if (seq > ws) begin
                pos = seq - ws;
                cur = pend;
                if (pos > WIN) begin
                    fault = 1;
                    return;
                end
                for (int i = 0; i < pos; i++) begin
                    if (recv[i]) begin
                        cur = sdu_s[i];
                        if (kind_s[i] >= FRAG_LAST) cur = -1;
                    end else begin
                        cur = -1;
                    end
                end
                for (int i = pos; i < WIN; i++) begin
                    recv[i - pos] = recv[i];
                    sdu_s[i - pos] = sdu_s[i];
                    kind_s[i - pos] = kind_s[i];
                end
                for (int i = WIN - pos; i < WIN; i++) recv[i] = 0;
                ws = seq;
                pend = cur;
            end
            add(RES_MOVE_ACK, {1'b0, ws}, 0, 0, 0, s);
        endfunction

        // predict the results of one accepted input transfer
        function void note_input(bit [1:0] op, bit [31:0] seq, bit [15:0] s, bit [1:0] k,
                                 bit [31:0] now);
            bit          r_recv [WIN];
            bit [15:0]   r_sdu [WIN];
            bit [1:0]    r_kind [WIN];
            bit [31:0]   r_ws, r_ne, r_rpt;
            int          r_pend;
            r_recv = recv; r_sdu = sdu_s; r_kind = kind_s;
            r_ws = ws; r_ne = ne; r_rpt = last_rpt; r_pend = pend;
            fault = 0;
            step_q.delete();
            case (op)
                OP_DATA:   data_pdu(seq, s, k, now);
                OP_MOVE:   move_window(seq, s);
                OP_REPORT: status_report(now);
                default:   fault = 1;
            endcase
            if (fault) begin
                recv = r_recv; sdu_s = r_sdu; kind_s = r_kind;
                ws = r_ws; ne = r_ne; last_rpt = r_rpt; pend = r_pend;
                step_q.delete();
                add(RES_ERROR, 0, 0, 0, 0, 0);
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
            foreach (step_q[i]) pending_q.insert(pending_q.size(), step_q[i]);
        endfunction

        function void check_result(t_win_result got);
            t_win_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d ack=%h", got.kind, got.ack);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected kind=%0d ack=%h bfs=%h bm=%h len=%0d sdu=%h last=%0d",
                             want.kind, want.ack, want.bfs, want.bm, want.blen, want.sdu,
                             want.last);
                    $display("          got      kind=%0d ack=%h bfs=%h bm=%h len=%0d sdu=%h last=%0d",
                             got.kind, got.ack, got.bfs, got.bm, got.blen, got.sdu,
                             got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_op;
    logic [31:0]        i_seq_num;
    logic [15:0]        i_sdu_id;
    logic [1:0]         i_frag_kind;
    logic [31:0]        i_now_time;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_kind;
    logic signed [32:0] o_ack_last_sn;
    logic [31:0]        o_bitmap_first_sn;
    logic [31:0]        o_bitmap;
    logic [5:0]         o_bitmap_len;
    logic [15:0]        o_out_sdu_id;
    logic               o_last;

    rlc_am_receive_window #(.WINDOW_SIZE(WIN)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_op(i_op),
        .i_seq_num(i_seq_num), .i_sdu_id(i_sdu_id), .i_frag_kind(i_frag_kind),
        .i_now_time(i_now_time), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_kind(o_kind), .o_ack_last_sn(o_ack_last_sn),
        .o_bitmap_first_sn(o_bitmap_first_sn), .o_bitmap(o_bitmap),
        .o_bitmap_len(o_bitmap_len), .o_out_sdu_id(o_out_sdu_id), .o_last(o_last)
    );

    t_window_scoreboard sb;
    bit [31:0] clock_now;
    int        idle_cycles;
    int        results_seen;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("rlc_am_receive_window verification failed");
            $finish;
        end
    end

    task automatic push_item(bit [1:0] op, bit [31:0] seq, bit [15:0] s, bit [1:0] k);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0) clock_now = $urandom;
        else clock_now = clock_now + $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op <= op; i_seq_num <= seq; i_sdu_id <= s; i_frag_kind <= k;
        i_now_time <= clock_now;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, seq, s, k, clock_now);
        @(negedge i_clk);
    endtask

    task automatic write_interval(bit [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.min_gap = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one random burst: mostly in-order SDUs, with moves, reports and faults mixed in
    task automatic random_traffic(int count);
        int        sent;
        int        r;
        int        len;
        int        span;
        bit [31:0] base;
        bit [31:0] seq;
        bit [15:0] s;
        sent = 0;
        while (sent < count) begin
            span = (sb.ne > sb.ws && sb.ne - sb.ws < WIN) ? int'(sb.ne - sb.ws) : 0;
            base = sb.ws + span;
            r = $urandom_range(0, 99);
            if (span > 22) begin
                push_item(OP_MOVE, sb.ws + $urandom_range(span - 4, span), 16'($urandom),
                          FRAG_MIDDLE);
                sent++;
            end else if (r < 55) begin
                len = $urandom_range(1, 4);
                s = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
                if (len == 1) begin
                    push_item(OP_DATA, base, s, FRAG_WHOLE);
                end else if ($urandom_range(0, 4) == 0) begin
                    // reordered tail arrives before the gap is filled
                    push_item(OP_DATA, base + len - 1, s, FRAG_LAST);
                    for (int i = 0; i < len - 1; i++)
                        push_item(OP_DATA, base + i, s, i == 0 ? FRAG_FIRST : FRAG_MIDDLE);
                end else begin
                    for (int i = 0; i < len; i++)
                        push_item(OP_DATA, base + i, s,
                                  i == 0 ? FRAG_FIRST : (i == len - 1 ? FRAG_LAST
                                                                      : FRAG_MIDDLE));
                end
                sent += len;
            end else if (r < 68) begin
                if ($urandom_range(0, 9) == 0) seq = sb.ws + WIN + 1;
                else if ($urandom_range(0, 9) == 0) seq = sb.ws - $urandom_range(0, 3);
                else seq = sb.ws + $urandom_range(0, span + 1);
                push_item(OP_MOVE, seq, 16'($urandom), 2'($urandom));
                sent++;
            end else if (r < 78) begin
                push_item(OP_REPORT, $urandom, 16'($urandom), 2'($urandom));
                sent++;
            end else if (r < 84) begin
                seq = sb.ws + $urandom_range(0, span);
                s = 16'($urandom);
                if (sb.recv[seq - sb.ws] && $urandom_range(0, 2) != 0)
                    s = sb.sdu_s[seq - sb.ws];
                push_item(OP_DATA, seq, s, 2'($urandom));
                sent++;
            end else if (r < 91) begin
                push_item(OP_DATA, sb.ws + $urandom_range(0, WIN - 1),
                          16'($urandom_range(0, 3)), 2'($urandom));
                sent++;
            end else if (r < 94) begin
                push_item(OP_DATA, sb.ws - $urandom_range(1, 40), 16'($urandom),
                          2'($urandom));
                sent++;
            end else if (r < 97) begin
                push_item(OP_DATA, $urandom, 16'($urandom), 2'($urandom));
                sent++;
            end else begin
                push_item(OP_BAD, $urandom, 16'($urandom), 2'($urandom));
                sent++;
            end
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        t_win_result got;
        int          gap;
        bit          held;
        held = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, 6);
            if (results_seen % 50 > 40) gap = 0;
            if (!held && results_seen == 60) begin
                held = 1;
                gap = 500;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.kind = o_kind; got.ack = o_ack_last_sn; got.bfs = o_bitmap_first_sn;
            got.bm = o_bitmap; got.blen = o_bitmap_len; got.sdu = o_out_sdu_id;
            got.last = o_last;
            sb.check_result(got);
            results_seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        sb = new();
        clock_now = 0;
        idle_cycles = 0;
        results_seen = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_op = OP_DATA; i_seq_num = '0; i_sdu_id = '0;
        i_frag_kind = FRAG_MIDDLE; i_now_time = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_interval(32'd0);
        push_item(OP_DATA, 0, 16'hFFFF, FRAG_WHOLE);
        push_item(OP_DATA, 1, 16'd5, FRAG_FIRST);
        push_item(OP_DATA, 2, 16'd5, FRAG_MIDDLE);
        push_item(OP_DATA, 3, 16'd5, FRAG_LAST);
        push_item(OP_DATA, 3, 16'd5, FRAG_LAST);     // duplicate, same sdu
        push_item(OP_DATA, 3, 16'd6, FRAG_LAST);     // duplicate, other sdu
        push_item(OP_REPORT, 0, 0, 0);
        push_item(OP_BAD, 32'hFFFF_FFFF, 16'hFFFF, FRAG_WHOLE);
        push_item(OP_DATA, 32'hFFFF_FFFF, 16'd1, FRAG_WHOLE);   // beyond window
        push_item(OP_DATA, 6, 16'd9, FRAG_FIRST);               // out of sequence
        push_item(OP_DATA, 7, 16'd8, FRAG_LAST);                // mixed sdus
        push_item(OP_DATA, 5, 16'd9, FRAG_WHOLE);               // misplaced whole
        push_item(OP_MOVE, 2, 16'd33, FRAG_MIDDLE);
        push_item(OP_MOVE, 0, 16'd34, FRAG_MIDDLE);             // not forward
        push_item(OP_MOVE, 2 + WIN + 1, 16'd35, FRAG_MIDDLE);   // too far
        push_item(OP_DATA, 1, 16'd1, FRAG_WHOLE);               // stale
        push_item(OP_MOVE, 8, 16'd0, FRAG_MIDDLE);
        push_item(OP_DATA, 8, 16'd77, FRAG_MIDDLE);             // middle, not pending
        push_item(OP_DATA, 9, 16'd0, FRAG_LAST);
        push_item(OP_MOVE, 8 + WIN, 16'hFFFF, FRAG_WHOLE);      // full shift
        drain();

        write_interval(32'd10);
        random_traffic(160);
        drain();
        write_interval(32'hFFFF_FFFF);
        random_traffic(90);
        drain();
        write_interval($urandom_range(1, 40));
        random_traffic(110);
        drain();
        write_interval(32'd0);
        random_traffic(100);
        drain();

        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("rlc_am_receive_window verification clean");
        end else begin
            $display("rlc_am_receive_window verification failed");
        end
        $finish;
    end
endmodule
